FILE: rtl/core/assert_macros.svh
// Assertion macros used by the datapath RTL file of the record sort block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Same-cycle implication outside reset
`define ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/rmsort_pkg.sv
// Types and constants of the record sort block
package rmsort_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int ADDR_W      = IDX_W + 1;
  localparam int MEM_DEPTH   = 2 ** ADDR_W;

  localparam int ID_W    = 6;
  localparam int PRICE_W = 31;
  localparam int COUNT_W = 31;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRICE_W-1:0] price;
    logic [COUNT_W-1:0] count;
  } rec_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic load_last;
    logic run_setup;
    logic merge_read;
    logic merge_step;
    logic emit_read;
    logic emit_take;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic single;
    logic run_end;
    logic pass_end;
    logic sort_end;
    logic emit_end;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/core/rmsort_in_if.sv
// Input channel: one product record per request
interface rmsort_in_if;
  logic                         valid;
  logic                         ready;
  logic [rmsort_pkg::ID_W-1:0]    item_id;
  logic [rmsort_pkg::PRICE_W-1:0] price_key;
  logic [rmsort_pkg::COUNT_W-1:0] stock_count;
  logic                         batch_end;

  modport source (output valid, item_id, price_key, stock_count, batch_end, input ready);
  modport sink   (input valid, item_id, price_key, stock_count, batch_end, output ready);
endinterface

FILE: rtl/core/rmsort_out_if.sv
// Output channel: one sorted record per request
interface rmsort_out_if;
  logic                         valid;
  logic                         ready;
  logic [rmsort_pkg::ID_W-1:0]    out_id;
  logic [rmsort_pkg::PRICE_W-1:0] out_price;
  logic [rmsort_pkg::COUNT_W-1:0] out_count;
  logic                         out_last;
  logic                         overflow;

  modport source (output valid, out_id, out_price, out_count, out_last, overflow, input ready);
  modport sink   (input valid, out_id, out_price, out_count, out_last, overflow, output ready);
endinterface

FILE: rtl/core/rmsort_ctrl.sv
// Sequencer for load, bottom-up merge passes and emit
module rmsort_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  rmsort_pkg::stat_t stat,
  output rmsort_pkg::cmd_t  cmd
);
  import rmsort_pkg::*;

  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_SETUP = 6'b000010,
    S_MREAD = 6'b000100,
    S_MSTEP = 6'b001000,
    S_EREAD = 6'b010000,
    S_EOUT  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_LOAD);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load      = 1'b1;
          cmd.load_last = in_last;
          if (in_last) begin
            state_next = stat.single ? S_EREAD : S_SETUP;
          end
        end
      end
      S_SETUP: begin
        cmd.run_setup = 1'b1;
        state_next    = S_MREAD;
      end
      S_MREAD: begin
        cmd.merge_read = 1'b1;
        state_next     = S_MSTEP;
      end
      S_MSTEP: begin
        cmd.merge_step = 1'b1;
        if (stat.run_end && stat.pass_end && stat.sort_end) begin
          state_next = S_EREAD;
        end else if (stat.run_end) begin
          state_next = S_SETUP;
        end else begin
          state_next = S_MREAD;
        end
      end
      S_EREAD: begin
        cmd.emit_read = 1'b1;
        state_next    = S_EOUT;
      end
      S_EOUT: begin
        // hold until the output register can take the record
        if (stat.out_free) begin
          cmd.emit_take = 1'b1;
          state_next    = stat.emit_end ? S_LOAD : S_EREAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

endmodule

FILE: rtl/core/rmsort_dp.sv
// Record memory, merge counters, key compare and output register
`include "assert_macros.svh"

module rmsort_dp (
  input  logic              clk,
  input  logic              rst,
  input  rmsort_pkg::cmd_t  cmd,
  output rmsort_pkg::stat_t stat,
  input  rmsort_pkg::rec_t  in_rec,
  output rmsort_pkg::rec_t  out_rec,
  output logic              out_last,
  output logic              out_ovf,
  output logic              out_valid,
  input  logic              out_ready
);
  import rmsort_pkg::*;

  // two banks: sources and destinations of alternate passes
  rec_t mem [MEM_DEPTH];

  cnt_t fill, n, w, lo, mid, hi, i, j, k;
  logic src, ovf, batch_ovf;
  rec_t rd_a, rd_b;

  logic             full, take_left;
  cnt_t             n_load, mid_calc, hi_calc;
  logic [CNT_W:0]   lo_w, lo_2w;
  logic [ADDR_W-1:0] addr_a, addr_b, addr_wr;

  assign full   = (fill == CNT_W'(MAX_RECORDS));
  assign n_load = full ? fill : fill + cnt_t'(1);

  assign lo_w     = {1'b0, lo} + {1'b0, w};
  assign lo_2w    = {1'b0, lo} + {w, 1'b0};
  assign mid_calc = (lo_w > {1'b0, n}) ? n : lo_w[CNT_W-1:0];
  assign hi_calc  = (lo_2w > {1'b0, n}) ? n : lo_2w[CNT_W-1:0];

  // stable: left run wins on equal price
  assign take_left = (i < mid) && ((j >= hi) || (rd_a.price <= rd_b.price));

  assign stat.single   = (n_load == cnt_t'(1));
  assign stat.run_end  = ({1'b0, k} + (CNT_W+1)'(1)) == {1'b0, hi};
  assign stat.pass_end = (hi == n);
  assign stat.sort_end = ({w, 1'b0} >= {1'b0, n});
  assign stat.emit_end = ({1'b0, k} + (CNT_W+1)'(1)) == {1'b0, n};
  assign stat.out_free = !out_valid || out_ready;

  assign addr_a  = cmd.merge_read ? {src, i[IDX_W-1:0]} : {src, k[IDX_W-1:0]};
  assign addr_b  = {src, j[IDX_W-1:0]};
  assign addr_wr = cmd.load ? {1'b0, fill[IDX_W-1:0]} : {~src, k[IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if ((cmd.load && !full) || cmd.merge_step) begin
      mem[addr_wr] <= cmd.load ? in_rec : (take_left ? rd_a : rd_b);
    end
    if (cmd.merge_read || cmd.emit_read) begin
      rd_a <= mem[addr_a];
    end
    if (cmd.merge_read) begin
      rd_b <= mem[addr_b];
    end
  end

  // batch fill and drop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      ovf  <= 1'b0;
    end else if (cmd.load) begin
      if (cmd.load_last) begin
        fill <= '0;
        ovf  <= 1'b0;
      end else if (!full) begin
        fill <= fill + cnt_t'(1);
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  // merge and emit sequencing registers
  always_ff @(posedge clk) begin
    if (cmd.load_last) begin
      n         <= n_load;
      batch_ovf <= ovf | full;
      w         <= cnt_t'(1);
      lo        <= '0;
      k         <= '0;
      src       <= 1'b0;
    end
    if (cmd.run_setup) begin
      mid <= mid_calc;
      hi  <= hi_calc;
      i   <= lo;
      j   <= mid_calc;
      k   <= lo;
    end
    if (cmd.merge_step) begin
      k <= k + cnt_t'(1);
      if (take_left) begin
        i <= i + cnt_t'(1);
      end else begin
        j <= j + cnt_t'(1);
      end
      if (stat.run_end) begin
        if (stat.pass_end) begin
          // flip banks, double the run width, rewind for the next pass or emit
          src <= ~src;
          lo  <= '0;
          w   <= w << 1;
          k   <= '0;
        end else begin
          lo <= hi;
        end
      end
    end
    if (cmd.emit_take) begin
      k <= k + cnt_t'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_take) begin
      out_rec  <= rd_a;
      out_last <= stat.emit_end;
      out_ovf  <= batch_ovf;
    end
  end

  `ASSERT_IMPL(a_merge_has_data, cmd.merge_step, (i < mid) || (j < hi), "merge step with both runs empty")
  `ASSERT_IMPL(a_merge_in_run, cmd.merge_step, (k >= lo) && (k < hi), "merge write outside its run")
  `ASSERT_IMPL(a_emit_free, cmd.emit_take, stat.out_free, "emit over a pending result")
  `ASSERT_CLK(a_fill_cap, fill <= CNT_W'(MAX_RECORDS), "fill count beyond capacity")

endmodule

FILE: rtl/core/record_merge_sort_by_price.sv
// Top level of the stable price sort of product records
// Records are loaded one per request into a 64-entry bank of a two-bank record memory;
// records past 64 in a batch are dropped and every result of that batch carries overflow.
// The request with batch_end starts the sort: ceil(log2 N) bottom-up merge passes
// ping-pong between the banks, each element taking a registered read of both run heads,
// then compare and write, plus a setup step for each run pair. Results then leave in
// ascending price order, equal prices in load order, each read through the memory read
// port into the output register, with out_last on the final one. Input is taken only
// between batches; the last result may still wait in the output register while the
// next batch loads.
module record_merge_sort_by_price (
  input logic         clk,
  input logic         rst,
  rmsort_in_if.sink   rec_in,
  rmsort_out_if.source rec_out
);
  import rmsort_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  rec_t  in_rec, out_rec;

  assign in_rec.id    = rec_in.item_id;
  assign in_rec.price = rec_in.price_key;
  assign in_rec.count = rec_in.stock_count;

  rmsort_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rec_in.valid),
    .in_last  (rec_in.batch_end),
    .in_ready (rec_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rmsort_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_rec    (in_rec),
    .out_rec   (out_rec),
    .out_last  (rec_out.out_last),
    .out_ovf   (rec_out.overflow),
    .out_valid (rec_out.valid),
    .out_ready (rec_out.ready)
  );

  assign rec_out.out_id    = out_rec.id;
  assign rec_out.out_price = out_rec.price;
  assign rec_out.out_count = out_rec.count;

endmodule
